### hdl/mdle_pkg.sv
// Shared types, widths and codes for the MAC directive list editor.
package mdle_pkg;

  localparam int CNT_W           = 8;
  localparam int ADDR_W          = 48;
  localparam int DIR_W           = 2;
  localparam int OP_W            = 3;
  localparam int ST_W            = 2;
  localparam int IN_W            = 64;
  localparam int OUT_W           = 64;
  localparam int MAX_ENTRIES_DEF = 255;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_ALL = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_UPDATED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

  // Access request from the sequencer to the entry store
  typedef struct packed {
    logic              wr_addr_en;
    logic              wr_dir_en;
    logic [CNT_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_address;
    logic [DIR_W-1:0]  wr_directive;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
  } mem_req_t;

  // Registered read data from the entry store
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DIR_W-1:0]  directive;
  } mem_rsp_t;

  // One result item
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] entry_address;
    logic [DIR_W-1:0]  entry_directive;
  } result_t;

endpackage

### hdl/mac_directive_list_editor.sv
// Top level of the MAC directive list editor: stream ports and output register.
//
// Keeps a list of up to MAX_ENTRIES (Ethernet address, directive) entries.
// in_*: one operation per item (clear, load, set_all, add, read).
// out_*: one result per item with status, count and the read entry.
// One item is worked on at a time; the next is taken once the result of
// the previous one sits in the output register, so a stalled receiver
// holds at most one result while the next item is already in progress.
// Path from accept to result in the output register:
//   clear, load, unused codes, out-of-range read: straight to the result state
//   read: through the read state, which takes the registered memory data
//   set_all: one directive write per entry; empty list straight to the result state
//   add: at most one memory read per entry, compare on the registered read data
// Reset empties the list (count 0) and drops any pending result; the
// entry memories are not cleared, only entries below the count are read.
module mac_directive_list_editor #(
  parameter int MAX_ENTRIES = mdle_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // operation[2:0], address[50:3], directive[52:51], index[60:53], zero[63:61]
  input  logic [mdle_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status[1:0], count[9:2], entry_address[57:10], entry_directive[59:58], zero[63:60]
  output logic [mdle_pkg::OUT_W-1:0] out_tdata
);
  import mdle_pkg::*;

  mem_req_t req;
  mem_rsp_t rsp;
  result_t  res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_r;
  result_t  out_res_r;

  mdle_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_operation (in_tdata[2:0]),
    .in_address   (in_tdata[50:3]),
    .in_directive (in_tdata[52:51]),
    .in_index     (in_tdata[60:53]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .req          (req),
    .rsp          (rsp)
  );

  mdle_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Output register: refills when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.entry_directive, out_res_r.entry_address,
                       out_res_r.count, out_res_r.status};

endmodule

### hdl/mdle_store.sv
// Entry store: address and directive memories, one write and one read port, registered read.
module mdle_store #(
  parameter int MAX_ENTRIES = mdle_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  mdle_pkg::mem_req_t req,
  output mdle_pkg::mem_rsp_t rsp
);
  import mdle_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [ADDR_W-1:0] addr_mem [MAX_ENTRIES];
  logic [DIR_W-1:0]  dir_mem  [MAX_ENTRIES];
  logic [ADDR_W-1:0] rd_addr_r;
  logic [DIR_W-1:0]  rd_dir_r;

  // Address memory
  always_ff @(posedge clk) begin
    if (req.wr_addr_en) begin
      addr_mem[req.wr_idx[IDX_W-1:0]] <= req.wr_address;
    end
    if (req.rd_en) begin
      rd_addr_r <= addr_mem[req.rd_idx[IDX_W-1:0]];
    end
  end

  // Directive memory
  always_ff @(posedge clk) begin
    if (req.wr_dir_en) begin
      dir_mem[req.wr_idx[IDX_W-1:0]] <= req.wr_directive;
    end
    if (req.rd_en) begin
      rd_dir_r <= dir_mem[req.rd_idx[IDX_W-1:0]];
    end
  end

  assign rsp.address   = rd_addr_r;
  assign rsp.directive = rd_dir_r;

endmodule

### hdl/mdle_seq.sv
// Operation sequencer: decodes items, walks the list, keeps the entry count.
module mdle_seq #(
  parameter int MAX_ENTRIES = mdle_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mdle_pkg::OP_W-1:0]   in_operation,
  input  logic [mdle_pkg::ADDR_W-1:0] in_address,
  input  logic [mdle_pkg::DIR_W-1:0]  in_directive,
  input  logic [mdle_pkg::CNT_W-1:0]  in_index,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mdle_pkg::result_t           res,
  output mdle_pkg::mem_req_t          req,
  input  mdle_pkg::mem_rsp_t          rsp
);
  import mdle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETALL = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] op_addr_r, op_addr_nxt;
  logic [DIR_W-1:0]  op_dir_r, op_dir_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [DIR_W-1:0]  rd_dir_r, rd_dir_nxt;
  logic              hit;

  assign hit = pend_r && (rsp.address == op_addr_r);

  // Next-state and memory request logic
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = 1'b0;
    op_addr_nxt = op_addr_r;
    op_dir_nxt  = op_dir_r;
    st_nxt      = st_r;
    rd_addr_nxt = rd_addr_r;
    rd_dir_nxt  = rd_dir_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    req         = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_addr_nxt = in_address;
          op_dir_nxt  = in_directive;
          st_nxt      = ST_OK;
          rd_addr_nxt = '0;
          rd_dir_nxt  = '0;
          ptr_nxt     = '0;
          state_nxt   = S_RESP;
          case (in_operation)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_LOAD: begin
              if (count_r >= MAX_CNT) begin
                st_nxt = ST_FULL;
              end else begin
                req.wr_addr_en   = 1'b1;
                req.wr_dir_en    = 1'b1;
                req.wr_idx       = count_r;
                req.wr_address   = in_address;
                req.wr_directive = in_directive;
                count_nxt        = count_r + 1'b1;
              end
            end
            OP_SET_ALL: begin
              if (count_r != '0) begin
                state_nxt = S_SETALL;
              end
            end
            OP_ADD: begin
              state_nxt = S_ADD;
            end
            OP_READ: begin
              if (in_index < count_r) begin
                req.rd_en  = 1'b1;
                req.rd_idx = in_index;
                state_nxt  = S_READ;
              end else begin
                st_nxt = ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // One directive write per cycle over the stored entries
      S_SETALL: begin
        req.wr_dir_en    = 1'b1;
        req.wr_idx       = ptr_r;
        req.wr_directive = op_dir_r;
        ptr_nxt          = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == count_r) begin
          state_nxt = S_RESP;
        end
      end

      // Read one entry per cycle, compare the one read in the previous cycle
      S_ADD: begin
        if (hit) begin
          req.wr_dir_en    = 1'b1;
          req.wr_idx       = cmp_idx_r;
          req.wr_directive = op_dir_r;
          st_nxt           = ST_UPDATED;
          state_nxt        = S_RESP;
        end else if (ptr_r < count_r) begin
          req.rd_en   = 1'b1;
          req.rd_idx  = ptr_r;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = ptr_r;
          ptr_nxt     = ptr_r + 1'b1;
        end else begin
          // No match anywhere: append, or report full
          state_nxt = S_RESP;
          if (count_r >= MAX_CNT) begin
            st_nxt = ST_FULL;
          end else begin
            req.wr_addr_en   = 1'b1;
            req.wr_dir_en    = 1'b1;
            req.wr_idx       = count_r;
            req.wr_address   = op_addr_r;
            req.wr_directive = op_dir_r;
            count_nxt        = count_r + 1'b1;
          end
        end
      end

      S_READ: begin
        rd_addr_nxt = rsp.address;
        rd_dir_nxt  = rsp.directive;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    op_addr_r <= op_addr_nxt;
    op_dir_r  <= op_dir_nxt;
    st_r      <= st_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_dir_r  <= rd_dir_nxt;
  end

  assign res.status          = st_r;
  assign res.count           = count_r;
  assign res.entry_address   = rd_addr_r;
  assign res.entry_directive = rd_dir_r;

endmodule

### tb/mac_directive_list_editor_tb.sv
// Self-checking stream testbench for the MAC directive list editor.
`timescale 1ns / 100ps

module mac_directive_list_editor_tb;
  import mdle_pkg::*;

  localparam int  LIST_DEPTH   = MAX_ENTRIES_DEF;
  localparam int  ITEM_TARGET  = 1100;
  localparam int  PHASE_ITEMS  = 110;
  localparam int  HOLD_CYCLES  = 800;
  localparam int  DRAIN_CYCLES = 300;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  REPORT_LIMIT = 10;

  // Directive codes
  localparam logic [DIR_W-1:0] DIR_NOOP      = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ADD       = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DELETE    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UNCHECKED = 2'd3;

  // Spare operation codes, accepted without effect
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

  typedef enum int {
    PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE, PH_BACKPRESSURE
  } tb_phase_e;

  // Directive list tracker: mirrors the entry store and queues expected results
  class directive_list_scoreboard;
    logic [ADDR_W-1:0] addr_store [0:LIST_DEPTH-1];
    logic [DIR_W-1:0]  dir_store  [0:LIST_DEPTH-1];
    int unsigned       entry_count;
    result_t           expected_results [$];
    int                failures;

    function new();
      entry_count = 0;
      failures    = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endfunction

    function logic [ST_W-1:0] append_entry(logic [ADDR_W-1:0] addr, logic [DIR_W-1:0] dir);
      if (entry_count >= LIST_DEPTH) return ST_FULL;
      addr_store[entry_count] = addr;
      dir_store[entry_count]  = dir;
      entry_count++;
      return ST_OK;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_input(logic [IN_W-1:0] word);
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [DIR_W-1:0]  dir;
      logic [CNT_W-1:0]  idx;
      result_t           want;
      bit                found;
      op   = word[2:0];
      addr = word[50:3];
      dir  = word[52:51];
      idx  = word[60:53];
      want = '0;
      want.status = ST_OK;
      found = 1'b0;
      case (op)
        OP_CLEAR: entry_count = 0;
        OP_LOAD: want.status = append_entry(addr, dir);
        OP_SET_ALL: begin
          for (int i = 0; i < entry_count; i++) dir_store[i] = dir;
        end
        OP_ADD: begin
          // only the first matching entry is updated
          for (int i = 0; i < entry_count && !found; i++) begin
            if (addr_store[i] == addr) begin
              dir_store[i] = dir;
              found = 1'b1;
            end
          end
          want.status = found ? ST_UPDATED : append_entry(addr, dir);
        end
        OP_READ: begin
          if (idx < entry_count) begin
            want.entry_address   = addr_store[idx];
            want.entry_directive = dir_store[idx];
          end else begin
            want.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      want.count = entry_count[CNT_W-1:0];
      expected_results.push_back(want);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [OUT_W-1:0] word);
      result_t got;
      result_t want;
      got.status          = word[1:0];
      got.count           = word[9:2];
      got.entry_address   = word[57:10];
      got.entry_directive = word[59:58];
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d count %0d addr %h dir %0d",
                         got.status, got.count, got.entry_address, got.entry_directive));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.entry_address !== want.entry_address ||
          got.entry_directive !== want.entry_directive)
        report($sformatf({"mismatch: status exp %0d got %0d, count exp %0d got %0d, ",
                          "addr exp %h got %h, dir exp %0d got %0d"},
                         want.status, got.status, want.count, got.count,
                         want.entry_address, got.entry_address,
                         want.entry_directive, got.entry_directive));
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  directive_list_scoreboard sb = new();
  tb_phase_e         phase       = PH_FREE;
  tb_phase_e         last_phase  = PH_FREE;
  int                hold_left   = 0;
  int                cycle_count = 0;
  int                items_sent  = 0;
  logic [ADDR_W-1:0] addr_pool [0:5];

  mac_directive_list_editor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle percentage of the sender or the receiver in each phase
  function automatic int idle_pct(tb_phase_e ph, bit receiver);
    case (ph)
      PH_SENDER_IDLE:    return receiver ? 0 : 79;
      PH_RECEIVER_STALL: return receiver ? 79 : 0;
      PH_BOTH_IDLE:      return 31;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // Receiver: random stalls, plus one long hold-off on entering backpressure
  always @(posedge clk) begin
    if (phase == PH_BACKPRESSURE && last_phase != PH_BACKPRESSURE) hold_left = HOLD_CYCLES;
    last_phase = phase;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct(phase, 1'b1));
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one item, wait for acceptance, then update the tracker
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DIR_W-1:0] dir, input logic [CNT_W-1:0] idx);
    logic [IN_W-1:0] word;
    word = {3'b000, idx, dir, addr, op};
    while ($urandom_range(99) < idle_pct(phase, 1'b0)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(word);
    items_sent++;
  endtask

  function automatic logic [ADDR_W-1:0] stored_address();
    return sb.addr_store[$urandom_range(sb.entry_count - 1)];
  endfunction

  // Fill the list with fresh addresses, push against the full list, then read near its end and set all
  task automatic fill_and_overflow();
    while (sb.entry_count < LIST_DEPTH)
      send_item($urandom_range(1) ? OP_LOAD : OP_ADD, random_address(),
                DIR_W'($urandom_range(3)), CNT_W'($urandom_range(255)));
    repeat (3) send_item(OP_LOAD, random_address(), DIR_W'($urandom_range(3)),
                         CNT_W'($urandom_range(255)));
    repeat (3) send_item(OP_ADD, random_address(), DIR_W'($urandom_range(3)),
                         CNT_W'($urandom_range(255)));
    repeat (3) send_item(OP_ADD, stored_address(), DIR_W'($urandom_range(3)),
                         CNT_W'($urandom_range(255)));
    send_item(OP_READ, random_address(), DIR_W'($urandom_range(3)), CNT_W'(LIST_DEPTH - 1));
    send_item(OP_READ, random_address(), DIR_W'($urandom_range(3)), CNT_W'(LIST_DEPTH));
    send_item(OP_SET_ALL, random_address(), DIR_W'($urandom_range(3)),
              CNT_W'($urandom_range(255)));
    send_item(OP_READ, random_address(), DIR_W'($urandom_range(3)),
              CNT_W'($urandom_range(LIST_DEPTH - 1)));
  endtask

  // Random mix of edits and reads, biased toward hits in the list
  task automatic run_mixed_burst(input int len);
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  idx;
    int                r;
    int                pick;
    repeat (len) begin
      r    = $urandom_range(99);
      pick = $urandom_range(99);
      addr = random_address();
      idx  = CNT_W'($urandom_range(255));
      if (r < 2) op = OP_CLEAR;
      else if (r < 22) op = OP_LOAD;
      else if (r < 30) op = OP_SET_ALL;
      else if (r < 62) op = OP_ADD;
      else if (r < 95) op = OP_READ;
      else op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      if ((op == OP_ADD || op == OP_LOAD) && sb.entry_count > 0 && pick < 40)
        addr = stored_address();
      else if ((op == OP_ADD || op == OP_LOAD) && pick < 70)
        addr = addr_pool[$urandom_range(5)];
      if (op == OP_READ && sb.entry_count > 0 && pick < 85)
        idx = CNT_W'($urandom_range(sb.entry_count - 1));
      send_item(op, addr, DIR_W'($urandom_range(3)), idx);
    end
  endtask

  initial begin
    int phase_sel;
    int next_phase_at;
    bit first_seq;
    foreach (addr_pool[i]) addr_pool[i] = random_address();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, spare codes, duplicates, first-match update, range, clear
    send_item(OP_READ, '0, DIR_NOOP, 8'd0);
    send_item(OP_SET_ALL, '0, DIR_ADD, 8'd0);
    send_item(OP_SPARE_A, '0, DIR_NOOP, 8'd0);
    send_item(OP_SPARE_B, ADDR_ONES, DIR_UNCHECKED, 8'hff);
    send_item(OP_SPARE_C, '0, DIR_NOOP, 8'd0);
    send_item(OP_LOAD, ADDR_ONES, DIR_UNCHECKED, 8'd0);
    send_item(OP_LOAD, '0, DIR_NOOP, 8'd0);
    send_item(OP_LOAD, ADDR_ONES, DIR_DELETE, 8'd0);
    send_item(OP_ADD, ADDR_ONES, DIR_ADD, 8'd0);
    send_item(OP_READ, '0, DIR_NOOP, 8'd0);
    send_item(OP_READ, '0, DIR_NOOP, 8'd2);
    send_item(OP_ADD, 48'h0000_0000_0001, DIR_DELETE, 8'd0);
    send_item(OP_ADD, 48'h8000_0000_0000, DIR_ADD, 8'd0);
    send_item(OP_READ, '0, DIR_NOOP, 8'd3);
    send_item(OP_READ, '0, DIR_NOOP, 8'd4);
    send_item(OP_READ, '0, DIR_NOOP, 8'd5);
    send_item(OP_READ, ADDR_ONES, DIR_UNCHECKED, 8'hff);
    send_item(OP_SET_ALL, '0, DIR_DELETE, 8'd0);
    send_item(OP_READ, '0, DIR_NOOP, 8'd1);
    send_item(OP_CLEAR, ADDR_ONES, DIR_UNCHECKED, 8'hff);
    send_item(OP_READ, '0, DIR_NOOP, 8'd0);
    send_item(OP_ADD, 48'h5555_5555_5555, DIR_NOOP, 8'd0);
    send_item(OP_READ, '0, DIR_NOOP, 8'd0);

    // Random sequences, rotating through the idle phases
    phase_sel     = 0;
    next_phase_at = items_sent + PHASE_ITEMS;
    first_seq     = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_phase_at) begin
        phase_sel++;
        phase <= tb_phase_e'(phase_sel % 5);
        next_phase_at += PHASE_ITEMS;
      end
      if (first_seq || $urandom_range(9) == 0) fill_and_overflow();
      else run_mixed_burst($urandom_range(10, 40));
      first_seq = 1'b0;
    end
    in_tvalid <= 1'b0;

    // Drain
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
